>>> src/tlf_pkg.sv
`timescale 1ns / 1ps

package tlf_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int LEN_W      = 5;
  localparam int START_W    = 32;
  localparam int LENGTH_W   = 33;
  localparam int COUNT_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_END_CHAR  = 2'd3;

  localparam logic [7:0] LINE_END_RESET = 8'd10;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic [START_W-1:0]  line_start;
    logic [LENGTH_W-1:0] line_length;
    logic [COUNT_W-1:0]  match_count;
    logic                ended_by_document;
  } line_rep_t;

  function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [3:0] idx);
    logic [63:0] word;
    word = idx[3] ? hi : lo;
    return word[{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage

>>> src/tlf_cell.sv
`timescale 1ns / 1ps

module tlf_cell #(
  parameter int POS = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tlf_pkg::cell_ctl_t        ctl,
  input  logic [7:0]                byte_in,
  input  logic                      valid_in,
  input  logic [63:0]               pat_low,
  input  logic [63:0]               pat_high,
  input  logic [tlf_pkg::LEN_W-1:0] pat_len,
  output logic [7:0]                byte_out,
  output logic                      valid_out,
  output logic                      ok
);
  import tlf_pkg::*;

  logic [7:0]       byte_r;
  logic             valid_r;
  logic [LEN_W-1:0] idx;
  logic             unused_pos;

  // This cell holds the byte that sits POS+1 places before the current one,
  // so it is compared against pattern byte len-2-POS.
  always_comb begin
    idx        = pat_len - LEN_W'(2) - LEN_W'(POS);
    unused_pos = (LEN_W'(POS) + LEN_W'(1)) >= pat_len;
    ok         = unused_pos || (valid_r && (byte_r == pat_byte(pat_low, pat_high, idx[3:0])));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out  = byte_r;
  assign valid_out = valid_r;

endmodule

>>> src/tlf_out_buf.sv
`timescale 1ns / 1ps

module tlf_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tlf_pkg::line_rep_t push_data,
  input  logic               pop,
  output logic               valid,
  output logic               full,
  output tlf_pkg::line_rep_t head
);
  import tlf_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  line_rep_t  slot0_r, slot0_nxt;
  line_rep_t  slot1_r, slot1_nxt;

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (pop && !push) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end else if (push && !pop) begin
      if (cnt_r == 2'd0) begin
        slot0_nxt = push_data;
      end else begin
        slot1_nxt = push_data;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else if (push && pop) begin
      if (cnt_r == 2'd1) begin
        slot0_nxt = push_data;
      end else begin
        slot0_nxt = slot1_r;
        slot1_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign valid = (cnt_r != 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = slot0_r;

endmodule

>>> src/token_line_finder.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake        Payload
// in_       input      valid / stall    data_byte, last_byte
// out_      output     valid / stall    line_start, line_length, match_count,
//                                        ended_by_document
// cfg_      input      write enable     index, data
//
// One byte is taken in every cycle unless input stalls; the compare over the row
// of window cells is done in the cycle the byte arrives and its report is pushed
// into a two-entry output buffer; input stalls only when that buffer is full.
// Reset is synchronous and active low and restores the configuration defaults.
// A transfer marked last returns the window and all counters to their reset state.

module token_line_finder #(
  parameter int MAX_PATTERN = tlf_pkg::MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = tlf_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tlf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tlf_pkg::START_W-1:0]    out_line_start,
  output logic [tlf_pkg::LENGTH_W-1:0]   out_line_length,
  output logic [tlf_pkg::COUNT_W-1:0]    out_match_count,
  output logic                           out_ended_by_document
);
  import tlf_pkg::*;

  localparam int WIN_N = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

  logic [63:0]       pat_low_r, pat_high_r;
  logic [LEN_W-1:0]  pat_len_r;
  logic [7:0]        line_end_r;

  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [OFFSET_BITS-1:0] line_start_r, line_start_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic [LEN_W-1:0]       block_r, block_nxt;

  logic [7:0]       cell_byte [WIN_N];
  logic [WIN_N-1:0] cell_valid;
  logic [WIN_N-1:0] cell_ok;
  cell_ctl_t        ctl;

  logic             in_accept;
  logic             buf_full;
  logic             pop;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] last_idx;
  logic             hit;
  logic [COUNT_W-1:0] count_upd;
  logic             at_end;
  logic             closing;
  logic             emit;
  logic [OFFSET_BITS-1:0] span;
  logic [64:0]      length_ext;
  logic [63:0]      start_ext;
  line_rep_t        rep;
  line_rep_t        head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
      line_end_r <= LINE_END_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:    pat_low_r  <= cfg_data;
        CFG_PATTERN_HIGH:   pat_high_r <= cfg_data;
        CFG_PATTERN_LENGTH: pat_len_r  <= cfg_data[LEN_W-1:0];
        CFG_LINE_END_CHAR:  line_end_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = buf_full;
  assign ctl.shift = in_accept;
  assign ctl.clear = in_accept && in_last_byte;

  assign len_eff = (pat_len_r > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_r;

  for (genvar j = 0; j < WIN_N; j++) begin : g_cell
    logic [7:0] b_in;
    logic       v_in;
    if (j == 0) begin : g_head
      assign b_in = in_data_byte;
      assign v_in = 1'b1;
    end else begin : g_link
      assign b_in = cell_byte[j-1];
      assign v_in = cell_valid[j-1];
    end
    tlf_cell #(
      .POS(j)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .byte_in  (b_in),
      .valid_in (v_in),
      .pat_low  (pat_low_r),
      .pat_high (pat_high_r),
      .pat_len  (len_eff),
      .byte_out (cell_byte[j]),
      .valid_out(cell_valid[j]),
      .ok       (cell_ok[j])
    );
  end

  always_comb begin
    last_idx = len_eff - LEN_W'(1);
    hit = (block_r == '0) && (len_eff != '0) && (&cell_ok)
          && (in_data_byte == pat_byte(pat_low_r, pat_high_r, last_idx[3:0]));

    block_nxt = block_r;
    count_upd = count_r;
    if (hit) begin
      block_nxt = last_idx;
      if (count_r != '1) begin
        count_upd = count_r + COUNT_W'(1);
      end
    end else if (block_r != '0) begin
      block_nxt = block_r - LEN_W'(1);
    end

    at_end  = (line_end_r != 8'd0) && (in_data_byte == line_end_r);
    closing = at_end || in_last_byte;
    emit    = closing && (line_end_r != 8'd0) && (count_upd != '0);

    span       = offset_r - line_start_r;
    length_ext = 65'(span) + 65'd1;
    start_ext  = 64'(line_start_r);
    rep.line_start        = start_ext[START_W-1:0];
    rep.line_length       = length_ext[LENGTH_W-1:0];
    rep.match_count       = count_upd;
    rep.ended_by_document = !at_end;

    line_start_nxt = line_start_r;
    count_nxt      = count_upd;
    if (closing) begin
      line_start_nxt = offset_r + OFFSET_BITS'(1);
      count_nxt      = '0;
    end
    offset_nxt = offset_r + OFFSET_BITS'(1);
    if (in_last_byte) begin
      offset_nxt     = '0;
      line_start_nxt = '0;
      count_nxt      = '0;
      block_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r     <= '0;
      line_start_r <= '0;
      count_r      <= '0;
      block_r      <= '0;
    end else if (in_accept) begin
      offset_r     <= offset_nxt;
      line_start_r <= line_start_nxt;
      count_r      <= count_nxt;
      block_r      <= block_nxt;
    end
  end

  assign pop = out_valid && !out_stall;

  tlf_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept && emit),
    .push_data(rep),
    .pop      (pop),
    .valid    (out_valid),
    .full     (buf_full),
    .head     (head)
  );

  assign out_line_start        = head.line_start;
  assign out_line_length       = head.line_length;
  assign out_match_count       = head.match_count;
  assign out_ended_by_document = head.ended_by_document;

endmodule

>>> src/tlf_checker.sv
`timescale 1ns / 1ps

module tlf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [tlf_pkg::START_W-1:0]    out_line_start,
  input logic [tlf_pkg::LENGTH_W-1:0]   out_line_length,
  input logic [tlf_pkg::COUNT_W-1:0]    out_match_count,
  input logic                           out_ended_by_document
);

  // After reset the result buffer is empty and input is open.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("results or stall present right after reset");

  // A reported line always holds a match and at least one byte.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_match_count != '0))
    else $error("report with zero match count");

  a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_length != '0))
    else $error("report with zero line length");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_line_start)
      && $stable(out_line_length) && $stable(out_match_count)
      && $stable(out_ended_by_document)))
    else $error("stalled result changed");

endmodule

bind token_line_finder tlf_checker u_tlf_checker (.*);

>>> dv/tb_token_line_finder.sv
`timescale 1ns / 1ps

module tb_token_line_finder;
  import tlf_pkg::*;

  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_LINE} exp_src_t;
  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  value;
    logic [7:0]             data;
    logic                   is_last;
    exp_src_t               src;
    line_rep_t              want;
  } step_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte = '0;
  logic                  in_last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [START_W-1:0]    out_line_start;
  logic [LENGTH_W-1:0]   out_line_length;
  logic [COUNT_W-1:0]    out_match_count;
  logic                  out_ended_by_document;

  exp_src_t  row_src = EXP_MODEL;
  line_rep_t row_line = '0;

  bit        calm = 1'b0;
  int        stall_left = 0;
  int        errors = 0;
  int        bytes_sent = 0;
  int        lines_checked = 0;
  int        writes_done = 0;
  line_rep_t pending_lines [$];

  logic [63:0] pat_lo, pat_hi;
  logic [4:0]  pat_len;
  logic [7:0]  eol;
  logic [7:0]  recent [15];
  int unsigned fill;
  logic [31:0] cur_offset, line_first;
  logic [15:0] line_count;
  int unsigned overlap_left;

  token_line_finder DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_data_byte          (in_data_byte),
    .in_last_byte          (in_last_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_line_start        (out_line_start),
    .out_line_length       (out_line_length),
    .out_match_count       (out_match_count),
    .out_ended_by_document (out_ended_by_document)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d line reports still pending", pending_lines.size());
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (errors < 50) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    errors++;
  endtask

  task automatic clear_document();
    foreach (recent[i]) recent[i] = 8'h00;
    fill = 0;
    cur_offset = '0;
    line_first = '0;
    line_count = '0;
    overlap_left = 0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic is_last, output logic found,
                           output line_rep_t rep);
    int unsigned len;
    logic hit;
    logic at_end;
    logic [127:0] pat;
    pat = {pat_hi, pat_lo};
    len = (pat_len > 5'd16) ? 16 : pat_len;
    hit = (overlap_left == 0) && (len != 0) && (fill + 1 >= len);
    if (hit && pat[(len - 1) * 8 +: 8] != b) hit = 1'b0;
    for (int k = 1; k < len; k++) begin
      if (hit && pat[(len - 1 - k) * 8 +: 8] != recent[k - 1]) hit = 1'b0;
    end
    if (hit) begin
      overlap_left = len - 1;
      if (line_count != 16'hFFFF) line_count++;
    end else if (overlap_left != 0) begin
      overlap_left--;
    end
    at_end = (eol != 8'h00) && (b == eol);
    found = 1'b0;
    rep = '0;
    if (at_end || is_last) begin
      if (eol != 8'h00 && line_count != 0) begin
        found = 1'b1;
        rep.line_start = line_first;
        rep.line_length = {1'b0, cur_offset - line_first} + 33'd1;
        rep.match_count = line_count;
        rep.ended_by_document = !at_end;
      end
      line_first = cur_offset + 32'd1;
      line_count = '0;
    end
    if (is_last) begin
      clear_document();
    end else begin
      for (int i = 14; i > 0; i--) recent[i] = recent[i - 1];
      recent[0] = b;
      if (fill < 15) fill++;
      cur_offset = cur_offset + 32'd1;
    end
  endtask

  // Tracks register writes and accepted transfers to build the expected reports.
  always @(posedge clk) begin : predict_lines
    logic found;
    line_rep_t rep;
    if (!rst_n) begin
      pat_lo = '0;
      pat_hi = '0;
      pat_len = '0;
      eol = LINE_END_RESET;
      clear_document();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PATTERN_LOW:    pat_lo = cfg_data;
          CFG_PATTERN_HIGH:   pat_hi = cfg_data;
          CFG_PATTERN_LENGTH: pat_len = cfg_data[4:0];
          CFG_LINE_END_CHAR:  eol = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        scan_byte(in_data_byte, in_last_byte, found, rep);
        case (row_src)
          EXP_MODEL: if (found) pending_lines.push_back(rep);
          EXP_LINE:  pending_lines.push_back(row_line);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_lines
    line_rep_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_lines.size() == 0) begin
        report_mismatch($sformatf("line report at %0d with none expected", out_line_start));
      end else begin
        want = pending_lines.pop_front();
        if (out_line_start !== want.line_start)
          report_mismatch($sformatf("line_start %0d, expected %0d",
                                    out_line_start, want.line_start));
        if (out_line_length !== want.line_length)
          report_mismatch($sformatf("line_length %0d, expected %0d",
                                    out_line_length, want.line_length));
        if (out_match_count !== want.match_count)
          report_mismatch($sformatf("match_count %0d, expected %0d",
                                    out_match_count, want.match_count));
        if (out_ended_by_document !== want.ended_by_document)
          report_mismatch($sformatf("ended_by_document %0b, expected %0b",
                                    out_ended_by_document, want.ended_by_document));
        lines_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic is_last, input exp_src_t src,
                           input line_rep_t want);
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= is_last;
    row_src <= src;
    row_line <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Registers change only once every expected report is out and the pipeline has drained.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    writes_done++;
  endtask

  function automatic step_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [63:0] value);
    step_row_t r;
    r = '{ROW_CFG, idx, value, 8'h00, 1'b0, EXP_NONE, '0};
    return r;
  endfunction

  function automatic step_row_t byte_row(input logic [7:0] data, input logic is_last,
                                         input exp_src_t src);
    step_row_t r;
    r = '{ROW_BYTE, '0, '0, data, is_last, src, '0};
    return r;
  endfunction

  function automatic step_row_t line_row(input logic [7:0] data, input logic is_last,
                                         input logic [31:0] start, input logic [32:0] length,
                                         input logic [15:0] count, input logic by_doc);
    step_row_t r;
    r = '{ROW_BYTE, '0, '0, data, is_last, EXP_LINE, '{start, length, count, by_doc}};
    return r;
  endfunction

  initial begin
    step_row_t   plan [$];
    int          plen, eff_len, cursor, copy_left, pick;
    logic [7:0]  eol_sel, base, b;
    logic [127:0] pat_bits;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan = '{
      byte_row(8'h78, 1'b0, EXP_NONE),
      byte_row(8'h0A, 1'b0, EXP_NONE),
      byte_row(8'hFF, 1'b1, EXP_NONE),
      cfg_row(CFG_PATTERN_LOW, 64'h6261),
      cfg_row(CFG_PATTERN_LENGTH, 64'd2),
      byte_row(8'h61, 1'b0, EXP_MODEL),
      byte_row(8'h62, 1'b0, EXP_MODEL),
      byte_row(8'h61, 1'b0, EXP_MODEL),
      byte_row(8'h62, 1'b0, EXP_MODEL),
      line_row(8'h0A, 1'b0, 32'd0, 33'd5, 16'd2, 1'b0),
      byte_row(8'h61, 1'b0, EXP_MODEL),
      line_row(8'h62, 1'b1, 32'd5, 33'd2, 16'd1, 1'b1),
      byte_row(8'h61, 1'b1, EXP_NONE),
      byte_row(8'h62, 1'b0, EXP_NONE),
      byte_row(8'h0A, 1'b1, EXP_NONE),
      cfg_row(CFG_PATTERN_LOW, 64'h6161),
      byte_row(8'h61, 1'b0, EXP_MODEL),
      byte_row(8'h61, 1'b0, EXP_MODEL),
      byte_row(8'h61, 1'b0, EXP_MODEL),
      line_row(8'h61, 1'b1, 32'd0, 33'd4, 16'd2, 1'b1),
      cfg_row(CFG_PATTERN_LOW, 64'h0A61),
      byte_row(8'h61, 1'b0, EXP_MODEL),
      line_row(8'h0A, 1'b0, 32'd0, 33'd2, 16'd1, 1'b0),
      byte_row(8'h7A, 1'b1, EXP_NONE),
      cfg_row(CFG_LINE_END_CHAR, 64'd0),
      cfg_row(CFG_PATTERN_LOW, '1),
      cfg_row(CFG_PATTERN_HIGH, '1),
      cfg_row(CFG_PATTERN_LENGTH, 64'd31),
      byte_row(8'hFF, 1'b0, EXP_MODEL),
      byte_row(8'h00, 1'b1, EXP_NONE)
    };
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_register(plan[i].idx, plan[i].value);
      end else begin
        send_byte(plan[i].data, plan[i].is_last, plan[i].src, plan[i].want);
      end
    end

    for (int phase = 0; phase < 20; phase++) begin
      calm = ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        plen = 31;
      end else if (phase == 2) begin
        plen = 0;
      end else if (phase == 3) begin
        plen = 16;
      end else begin
        case ($urandom_range(0, 9))
          0: plen = $urandom_range(17, 30);
          1: plen = $urandom_range(5, 15);
          default: plen = $urandom_range(1, 4);
        endcase
      end
      base = 8'($urandom_range(0, 253));
      for (int i = 0; i < 16; i++) begin
        pat_bits[i * 8 +: 8] = (phase % 4 == 0) ? 8'($urandom)
                                                : base + 8'($urandom_range(0, 2));
      end
      if (phase % 5 == 4) begin
        eol_sel = 8'h00;
      end else if (phase == 6) begin
        eol_sel = 8'hFF;
      end else if ($urandom_range(0, 3) == 0) begin
        eol_sel = 8'($urandom);
      end else begin
        eol_sel = 8'h0A;
      end
      write_register(CFG_PATTERN_LOW, pat_bits[63:0]);
      write_register(CFG_PATTERN_HIGH, pat_bits[127:64]);
      write_register(CFG_PATTERN_LENGTH, 64'(plen));
      write_register(CFG_LINE_END_CHAR, 64'(eol_sel));

      // Mostly whole copies of the pattern, mixed with near misses, line ends and noise.
      eff_len = (plen > 16) ? 16 : ((plen == 0) ? 1 : plen);
      cursor = 0;
      copy_left = 0;
      repeat (100) begin
        if (copy_left != 0) begin
          b = pat_bits[cursor * 8 +: 8];
          cursor++;
          copy_left--;
          if ($urandom_range(0, 39) == 0) b = 8'($urandom);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 8) begin
            b = eol_sel;
          end else if (pick < 45) begin
            b = pat_bits[7:0];
            cursor = 1;
            copy_left = eff_len - 1;
          end else if (pick < 80) begin
            b = base + 8'($urandom_range(0, 2));
          end else begin
            b = 8'($urandom);
          end
        end
        send_byte(b, $urandom_range(0, 59) == 0, EXP_MODEL, '0);
      end
    end

    // A final stretch without idling runs one long line of single-byte matches.
    calm = 1'b1;
    write_register(CFG_PATTERN_LOW, 64'h71);
    write_register(CFG_PATTERN_LENGTH, 64'd1);
    write_register(CFG_LINE_END_CHAR, 64'h0A);
    repeat (200) send_byte(8'h71, 1'b0, EXP_MODEL, '0);
    send_byte(8'h0A, 1'b1, EXP_MODEL, '0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d document bytes over %0d register writes, checked %0d line reports.",
             bytes_sent, writes_done, lines_checked);
    $display("Covered short and clamped patterns, overlaps, line ends and no line end.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
